>>> rtl/rrts_pkg.sv
// Shared types and constants for the round-robin thread scheduler.
// Holds the payload structs, the thread status codes and the
// controller/datapath command and status types. No dependencies.
package rrts_pkg;

  // Width of thread ids carried on the ports.
  localparam int ID_W = 7;

  // Event kinds.
  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_EXIT   = 2'd1;
  localparam logic [1:0] KIND_JOIN   = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  // Result status codes.
  localparam logic [1:0] RES_OK    = 2'd0;
  localparam logic [1:0] RES_FULL  = 2'd1;
  localparam logic [1:0] RES_NORUN = 2'd2;

  // Thread status codes held in the thread table.
  localparam logic [2:0] TS_EMPTY   = 3'd0;
  localparam logic [2:0] TS_READY   = 3'd1;
  localparam logic [2:0] TS_EXITED  = 3'd2;
  localparam logic [2:0] TS_SETUP   = 3'd4;
  localparam logic [2:0] TS_BLOCKED = 3'd5;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] target_thread;
  } in_item_t;

  // Output transaction payload.
  typedef struct packed {
    logic [ID_W-1:0] new_thread;
    logic [ID_W-1:0] running_thread;
    logic [1:0]      status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef enum logic [4:0] {
    OP_NONE          = 5'd0,
    OP_CLEAR         = 5'd1,
    OP_LOAD_IN       = 5'd2,
    OP_START_CREATE  = 5'd3,
    OP_START_RECLAIM = 5'd4,
    OP_START_SCHED   = 5'd5,
    OP_RUN_CREATE    = 5'd6,
    OP_RUN_RECLAIM   = 5'd7,
    OP_RUN_SCHED     = 5'd8,
    OP_READ_CUR      = 5'd9,
    OP_READ_TGT      = 5'd10,
    OP_READ_JNR      = 5'd11,
    OP_EXIT_WR       = 5'd12,
    OP_JNR_WR        = 5'd13,
    OP_TGT_WR        = 5'd14,
    OP_CUR_WR        = 5'd15,
    OP_LOAD_OUT      = 5'd16
  } dp_op_e;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       cur_zero;
    logic       tgt_in_range;
    logic       tgt_joinable;
    logic       rd_jvalid;
    logic       rd_blocked;
    logic       create_hit;
    logic       sched_hit;
    logic       scan_done;
  } dp_status_t;

endpackage

>>> rtl/round_robin_thread_scheduler_top.sv
// After the accepting edge the event is dispatched; create then searches the table for a free slot,
// exit and join perform their table reads and writes, and tick goes straight to a reschedule.
// A reschedule first sweeps the table to reclaim exited entries when thread zero is current, then
// searches round robin for a ready thread, one table probe per cycle.
// A final state registers the result and waits while the output is stalled; one event at a time.
// After reset the table is cleared before the first event is taken.
module round_robin_thread_scheduler_top import rrts_pkg::*; #(
  parameter int THREAD_SLOTS = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  dp_op_e     op;
  dp_status_t dp_status;

  // Sequencing and handshakes.
  rrts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (dp_status),
    .op_o       (op)
  );

  // Thread table and scheduler registers.
  rrts_dp #(
    .THREAD_SLOTS(THREAD_SLOTS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (op),
    .in_item_i (in_data_i),
    .out_item_o(out_data_o),
    .status_o  (dp_status)
  );

endmodule

>>> rtl/rrts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read-first on a same-address collision. No dependencies.
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rrts_dp.sv
// Datapath of the thread scheduler: thread table RAM, scan engine and
// scheduler registers. Depends on rrts_pkg and rrts_ram.
module rrts_dp import rrts_pkg::*; #(
  parameter int THREAD_SLOTS = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_op_e     op_i,
  input  in_item_t   in_item_i,
  output out_item_t  out_item_o,
  output dp_status_t status_o
);

  localparam int IDW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int CW  = $clog2(THREAD_SLOTS + 1);
  localparam logic [IDW-1:0] LAST_SLOT  = IDW'(THREAD_SLOTS - 1);
  localparam logic [CW-1:0]  SLOT_COUNT = CW'(THREAD_SLOTS);

  // One thread table entry.
  typedef struct packed {
    logic [2:0]     status;
    logic [2:0]     saved;
    logic           jvalid;
    logic [IDW-1:0] jid;
    logic           live;
  } entry_t;

  localparam int EW = $bits(entry_t);

  logic [1:0]     kind_q, kind_d;
  logic [ID_W-1:0] target_q, target_d;
  logic [IDW-1:0] cur_q, cur_d;
  logic [IDW-1:0] last_q, last_d;
  logic [IDW-1:0] live_cnt_q, live_cnt_d;
  logic [IDW-1:0] jid_q, jid_d;
  logic [IDW-1:0] res_new_q, res_new_d;
  logic [1:0]     res_stat_q, res_stat_d;
  logic [IDW-1:0] probe_q, probe_d;
  logic [CW-1:0]  issued_q, issued_d;
  logic           chk_vld_q, chk_vld_d;
  logic [IDW-1:0] chk_addr_q, chk_addr_d;
  out_item_t      out_q, out_d;

  logic           ram_we;
  logic [IDW-1:0] ram_waddr;
  logic [IDW-1:0] ram_raddr;
  entry_t         ram_wdata;
  entry_t         rd_entry;
  logic [EW-1:0]  ram_rdata;

  logic           issue;
  logic           only_zero;
  logic           scan_done;
  logic           create_hit;
  logic           sched_hit;
  logic [IDW-1:0] tgt_addr;

  // Next slot in scan order; past the last slot the scan wraps to 0 or 1.
  function automatic logic [IDW-1:0] next_slot(input logic [IDW-1:0] p,
                                               input logic wrap_one);
    logic [IDW-1:0] n;
    if (p == LAST_SLOT) begin
      n = IDW'(wrap_one);
    end else begin
      n = p + IDW'(1);
    end
    return n;
  endfunction

  // Thread table.
  rrts_ram #(
    .WIDTH(EW),
    .DEPTH(THREAD_SLOTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // Scan engine and entry status decode.
  assign issue      = (issued_q != SLOT_COUNT);
  assign only_zero  = (live_cnt_q == '0);
  assign scan_done  = !chk_vld_q && !issue;
  assign create_hit = chk_vld_q && (chk_addr_q != '0) && !rd_entry.live;
  assign sched_hit  = chk_vld_q &&
                      ((rd_entry.status == TS_READY) || (rd_entry.status == TS_SETUP));
  assign tgt_addr   = IDW'(target_q);

  assign status_o.kind         = kind_q;
  assign status_o.cur_zero     = (cur_q == '0);
  assign status_o.tgt_in_range = (32'(target_q) < 32'(THREAD_SLOTS));
  assign status_o.tgt_joinable = (rd_entry.status != TS_EMPTY) &&
                                 (rd_entry.status != TS_EXITED) && !rd_entry.jvalid;
  assign status_o.rd_jvalid    = rd_entry.jvalid;
  assign status_o.rd_blocked   = (rd_entry.status == TS_BLOCKED);
  assign status_o.create_hit   = create_hit;
  assign status_o.sched_hit    = sched_hit;
  assign status_o.scan_done    = scan_done;

  // Command decode: table access and register updates.
  always_comb begin
    kind_d     = kind_q;
    target_d   = target_q;
    cur_d      = cur_q;
    last_d     = last_q;
    live_cnt_d = live_cnt_q;
    jid_d      = jid_q;
    res_new_d  = res_new_q;
    res_stat_d = res_stat_q;
    probe_d    = probe_q;
    issued_d   = issued_q;
    chk_vld_d  = 1'b0;
    chk_addr_d = chk_addr_q;
    out_d      = out_q;
    ram_we     = 1'b0;
    ram_waddr  = chk_addr_q;
    ram_wdata  = rd_entry;
    ram_raddr  = probe_q;

    unique case (op_i)
      OP_NONE: begin
      end
      OP_CLEAR: begin
        if (issue) begin
          ram_we    = 1'b1;
          ram_waddr = probe_q;
          ram_wdata = '0;
          ram_wdata.status = (probe_q == '0) ? TS_READY : TS_EMPTY;
          probe_d   = next_slot(probe_q, 1'b0);
          issued_d  = issued_q + CW'(1);
        end
      end
      OP_LOAD_IN: begin
        kind_d     = in_item_i.kind;
        target_d   = in_item_i.target_thread;
        res_new_d  = '0;
        res_stat_d = RES_OK;
      end
      OP_START_CREATE: begin
        probe_d  = last_q;
        issued_d = '0;
      end
      OP_START_RECLAIM: begin
        probe_d  = '0;
        issued_d = '0;
      end
      OP_START_SCHED: begin
        probe_d  = next_slot(cur_q, !only_zero);
        issued_d = '0;
      end
      OP_RUN_CREATE: begin
        if (issue) begin
          probe_d    = next_slot(probe_q, 1'b0);
          issued_d   = issued_q + CW'(1);
          chk_vld_d  = 1'b1;
          chk_addr_d = probe_q;
        end
        // Claim the free slot found by the search.
        if (create_hit) begin
          ram_we           = 1'b1;
          ram_wdata.status = TS_SETUP;
          ram_wdata.jvalid = 1'b0;
          ram_wdata.jid    = '0;
          ram_wdata.live   = 1'b1;
          last_d           = chk_addr_q;
          res_new_d        = chk_addr_q;
          live_cnt_d       = live_cnt_q + IDW'(1);
        end
        if (scan_done) begin
          res_stat_d = RES_FULL;
        end
      end
      OP_RUN_RECLAIM: begin
        if (issue) begin
          probe_d    = next_slot(probe_q, 1'b0);
          issued_d   = issued_q + CW'(1);
          chk_vld_d  = 1'b1;
          chk_addr_d = probe_q;
        end
        if (chk_vld_q && (rd_entry.status == TS_EXITED)) begin
          ram_we           = 1'b1;
          ram_wdata.status = TS_EMPTY;
        end
      end
      OP_RUN_SCHED: begin
        if (issue) begin
          probe_d    = next_slot(probe_q, !only_zero);
          issued_d   = issued_q + CW'(1);
          chk_vld_d  = 1'b1;
          chk_addr_d = probe_q;
        end
        // The chosen thread becomes current and is marked ready.
        if (sched_hit) begin
          ram_we           = 1'b1;
          ram_wdata.status = TS_READY;
          cur_d            = chk_addr_q;
        end
        if (scan_done) begin
          res_stat_d = RES_NORUN;
        end
      end
      OP_READ_CUR: begin
        ram_raddr = cur_q;
      end
      OP_READ_TGT: begin
        ram_raddr = tgt_addr;
      end
      OP_READ_JNR: begin
        ram_raddr = jid_q;
      end
      OP_EXIT_WR: begin
        ram_we           = 1'b1;
        ram_waddr        = cur_q;
        ram_wdata.status = TS_EXITED;
        ram_wdata.live   = 1'b0;
        jid_d            = rd_entry.jid;
        if (rd_entry.live && (cur_q != '0)) begin
          live_cnt_d = live_cnt_q - IDW'(1);
        end
      end
      OP_JNR_WR: begin
        ram_we           = 1'b1;
        ram_waddr        = jid_q;
        ram_wdata.status = rd_entry.saved;
      end
      OP_TGT_WR: begin
        ram_we           = 1'b1;
        ram_waddr        = tgt_addr;
        ram_wdata.jvalid = 1'b1;
        ram_wdata.jid    = cur_q;
      end
      OP_CUR_WR: begin
        ram_we           = 1'b1;
        ram_waddr        = cur_q;
        ram_wdata.saved  = rd_entry.status;
        ram_wdata.status = TS_BLOCKED;
      end
      OP_LOAD_OUT: begin
        out_d.new_thread     = ID_W'(res_new_q);
        out_d.running_thread = ID_W'(cur_q);
        out_d.status         = res_stat_q;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q      <= '0;
      last_q     <= '0;
      live_cnt_q <= '0;
      probe_q    <= '0;
      issued_q   <= '0;
      chk_vld_q  <= 1'b0;
    end else begin
      cur_q      <= cur_d;
      last_q     <= last_d;
      live_cnt_q <= live_cnt_d;
      probe_q    <= probe_d;
      issued_q   <= issued_d;
      chk_vld_q  <= chk_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    target_q   <= target_d;
    jid_q      <= jid_d;
    res_new_q  <= res_new_d;
    res_stat_q <= res_stat_d;
    chk_addr_q <= chk_addr_d;
    out_q      <= out_d;
  end

  assign out_item_o = out_q;

  // Consistency checks on the scan engine and scheduler registers.
  a_cur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_q) < 32'(THREAD_SLOTS))
    else $error("current thread outside the table");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issued_q <= SLOT_COUNT)
    else $error("scan issued more probes than slots");

  a_hit_vs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((create_hit || sched_hit) && scan_done))
    else $error("scan reports a hit after it finished");

  a_live_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_cnt_q <= LAST_SLOT)
    else $error("live slot count exceeds table size");

  a_sched_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_RUN_SCHED && sched_hit) |=> (cur_q == $past(chk_addr_q)))
    else $error("scheduled thread was not made current");

endmodule

>>> rtl/rrts_ctrl.sv
// Controller state machine of the thread scheduler: sequences table reads,
// writes and scans, and owns the handshakes. Depends on rrts_pkg.
module rrts_ctrl import rrts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_op_e     op_o
);

  typedef enum logic [13:0] {
    S_INIT    = 14'b00000000000001,
    S_IDLE    = 14'b00000000000010,
    S_DISP    = 14'b00000000000100,
    S_C_SRCH  = 14'b00000000001000,
    S_X_EV    = 14'b00000000010000,
    S_X_JRD   = 14'b00000000100000,
    S_X_JEV   = 14'b00000001000000,
    S_J_TEV   = 14'b00000010000000,
    S_J_CRD   = 14'b00000100000000,
    S_J_CEV   = 14'b00001000000000,
    S_R_START = 14'b00010000000000,
    S_R_CLR   = 14'b00100000000000,
    S_R_SRCH  = 14'b01000000000000,
    S_FIN     = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  dp_op_e op;

  // Next state and datapath command.
  always_comb begin
    state_d = state_q;
    op      = OP_NONE;
    unique case (state_q)
      S_INIT: begin
        op = OP_CLEAR;
        if (status_i.scan_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op      = OP_LOAD_IN;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (status_i.kind)
          KIND_CREATE: begin
            op      = OP_START_CREATE;
            state_d = S_C_SRCH;
          end
          KIND_EXIT: begin
            op      = OP_READ_CUR;
            state_d = S_X_EV;
          end
          KIND_JOIN: begin
            if (status_i.tgt_in_range) begin
              op      = OP_READ_TGT;
              state_d = S_J_TEV;
            end else begin
              state_d = S_FIN;
            end
          end
          default: begin
            state_d = S_R_START;
          end
        endcase
      end
      S_C_SRCH: begin
        op = OP_RUN_CREATE;
        if (status_i.create_hit || status_i.scan_done) begin
          state_d = S_FIN;
        end
      end
      S_X_EV: begin
        op      = OP_EXIT_WR;
        state_d = status_i.rd_jvalid ? S_X_JRD : S_R_START;
      end
      S_X_JRD: begin
        op      = OP_READ_JNR;
        state_d = S_X_JEV;
      end
      S_X_JEV: begin
        if (status_i.rd_blocked) begin
          op = OP_JNR_WR;
        end
        state_d = S_R_START;
      end
      S_J_TEV: begin
        if (status_i.tgt_joinable) begin
          op      = OP_TGT_WR;
          state_d = S_J_CRD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_J_CRD: begin
        op      = OP_READ_CUR;
        state_d = S_J_CEV;
      end
      S_J_CEV: begin
        op      = OP_CUR_WR;
        state_d = S_R_START;
      end
      S_R_START: begin
        // Thread zero running: reclaim exited entries before the search.
        if (status_i.cur_zero) begin
          op      = OP_START_RECLAIM;
          state_d = S_R_CLR;
        end else begin
          op      = OP_START_SCHED;
          state_d = S_R_SRCH;
        end
      end
      S_R_CLR: begin
        if (status_i.scan_done) begin
          op      = OP_START_SCHED;
          state_d = S_R_SRCH;
        end else begin
          op = OP_RUN_RECLAIM;
        end
      end
      S_R_SRCH: begin
        op = OP_RUN_SCHED;
        if (status_i.sched_hit || status_i.scan_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          op      = OP_LOAD_OUT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register holds a result until the output transaction completes.
  assign out_valid_d = (out_valid_q && !out_ready_i) || (op == OP_LOAD_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign op_o        = op;

  // A result is loaded only once the previous one has left.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_LOAD_OUT) |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // Leaving the reset clearing pass requires the pass to be complete.
  a_init_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT && state_d == S_IDLE) |-> status_i.scan_done)
    else $error("left table clear early");

  // A search state is left only on a hit or at the end of the scan.
  a_srch_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_R_SRCH && state_d != S_R_SRCH) |->
    (status_i.sched_hit || status_i.scan_done))
    else $error("schedule search left without a result");

endmodule
